>>> rtl/chp_pkg.sv
// Shared constants, record codes and types for the ClientHello parser.
package chp_pkg;

  // Offsets saturate at this value (17-bit outputs)
  localparam logic [16:0] OFFSET_LIMIT = 17'h1FFFF;
  localparam logic [7:0]  SID_MAX      = 8'd32;
  localparam logic [15:0] RANDOM_LEN   = 16'd32;

  // Queue between parser front and output back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Record kinds
  localparam logic [2:0] KIND_VERSION = 3'd0;
  localparam logic [2:0] KIND_SID_LEN = 3'd1;
  localparam logic [2:0] KIND_SUITE   = 3'd2;
  localparam logic [2:0] KIND_COMP    = 3'd3;
  localparam logic [2:0] KIND_EXT     = 3'd4;
  localparam logic [2:0] KIND_STATUS  = 3'd5;

  // Final status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_INCOMPLETE = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED  = 2'd2;

  typedef logic [16:0] offset_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [15:0] value;
    logic [15:0] ext_length;
    offset_t     ext_offset;
    logic [1:0]  status;
    offset_t     consumed;
    logic        last_of_run;
  } rec_t;

  // Everything one input byte produces: one or two records
  typedef struct packed {
    rec_t rec0;
    rec_t rec1;
    logic two;
  } pair_t;

endpackage

>>> rtl/chp_ifs.sv
// Stream interfaces: input bytes and output records.
interface chp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface chp_rec_if;
  import chp_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [15:0] value;
  logic [15:0] ext_length;
  offset_t     ext_offset;
  logic [1:0]  status;
  offset_t     consumed;
  logic        last_of_run;

  modport source (output valid, output record_kind, output value, output ext_length,
                  output ext_offset, output status, output consumed,
                  output last_of_run, input ready);
  modport sink   (input valid, input record_kind, input value, input ext_length,
                  input ext_offset, input status, input consumed,
                  input last_of_run, output ready);
endinterface

>>> rtl/client_hello_parser_core.sv
// ClientHello parser top: parser front, pair queue, record output back.
// Throughput: one byte per cycle while the queue is not full; a byte that yields two records outputs them in turn.
// A record passes from its accepted byte through a queue slot into the output register; a second waits in pend_rec_q.
// The front and back decouple through a four-entry queue; ready drops only when it is full.
// Reset (rst_ni low, asynchronous) returns the parser to the version field, empties the queue.
module client_hello_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  chp_byte_if.sink   byte_i,
  chp_rec_if.source  rec_o
);
  import chp_pkg::*;

  logic  push, full, q_valid, pop;
  pair_t push_data, q_data;

  chp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  chp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  chp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .pop_o     (pop),
    .rec_o     (rec_o)
  );

endmodule

>>> rtl/chp_front.sv
// Parser front: accepts bytes, tracks message phase, builds result records.
module chp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  chp_byte_if.sink       byte_i,
  input  logic           full_i,
  output logic           push_o,
  output chp_pkg::pair_t push_data_o
);
  import chp_pkg::*;

  typedef enum logic [3:0] {
    PH_VER_HI, PH_VER_LO, PH_RANDOM, PH_SID_LEN, PH_SID, PH_CS_HI, PH_CS_LO,
    PH_SUITES, PH_COMP_LEN, PH_COMP, PH_EXTS_HI, PH_EXTS_LO, PH_EXT_HDR,
    PH_EXT_DATA, PH_DONE, PH_DOOMED
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] field_count_q, field_count_d;
  logic [15:0] field_length_q, field_length_d;
  offset_t     byte_offset_q, byte_offset_d;
  offset_t     ext_region_end_q, ext_region_end_d;
  logic [15:0] ext_type_q, ext_type_d;
  offset_t     ext_data_offset_q, ext_data_offset_d;
  logic [7:0]  high_byte_q, high_byte_d;
  logic        discarding_q, discarding_d;
  logic [1:0]  hdr_index_q, hdr_index_d;
  logic [15:0] data_left_q, data_left_d;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic [15:0] word;
  offset_t     pos;
  logic [15:0] fc_dec;
  logic [15:0] dl_dec;
  logic        bad;
  logic        e_v;
  rec_t        e_r;
  logic        s_v;
  rec_t        s_r;
  logic        clear_st;
  pair_t       pair;

  function automatic offset_t sat_add(offset_t a, offset_t c);
    logic [17:0] sum;
    sum = {1'b0, a} + {1'b0, c};
    return (sum > {1'b0, OFFSET_LIMIT}) ? OFFSET_LIMIT : sum[16:0];
  endfunction

  function automatic rec_t mk_rec(logic [2:0] kind, logic [15:0] val, logic [15:0] elen,
                                  offset_t eoff, logic [1:0] st, offset_t cons);
    rec_t r;
    r.record_kind = kind;
    r.value       = val;
    r.ext_length  = elen;
    r.ext_offset  = eoff;
    r.status      = st;
    r.consumed    = cons;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  assign byte_i.ready = !full_i;
  assign accept = byte_i.valid && !full_i;
  assign b      = byte_i.data_byte;
  assign last   = byte_i.last_byte;
  assign word   = {high_byte_q, b};
  assign pos    = (byte_offset_q >= OFFSET_LIMIT) ? OFFSET_LIMIT : byte_offset_q + 17'd1;
  assign fc_dec = field_count_q - 16'd1;
  assign dl_dec = data_left_q - 16'd1;

  // Next state and records for the accepted byte
  always_comb begin
    phase_d           = phase_q;
    field_count_d     = field_count_q;
    field_length_d    = field_length_q;
    byte_offset_d     = byte_offset_q;
    ext_region_end_d  = ext_region_end_q;
    ext_type_d        = ext_type_q;
    ext_data_offset_d = ext_data_offset_q;
    high_byte_d       = high_byte_q;
    discarding_d      = discarding_q;
    hdr_index_d       = hdr_index_q;
    data_left_d       = data_left_q;
    bad      = 1'b0;
    e_v      = 1'b0;
    e_r      = '0;
    s_v      = 1'b0;
    s_r      = '0;
    clear_st = 1'b0;

    if (accept && discarding_q) begin
      clear_st = last;
    end else if (accept) begin
      if (phase_q != PH_DONE && phase_q != PH_DOOMED) begin
        byte_offset_d = pos;
      end
      unique case (phase_q)
        PH_VER_HI: begin
          high_byte_d = b;
          phase_d     = PH_VER_LO;
        end
        PH_VER_LO: begin
          e_v = 1'b1;
          e_r = mk_rec(KIND_VERSION, word, '0, '0, STATUS_OK, '0);
          field_count_d = RANDOM_LEN;
          phase_d       = PH_RANDOM;
        end
        PH_RANDOM: begin
          field_count_d = fc_dec;
          if (fc_dec == '0) phase_d = PH_SID_LEN;
        end
        PH_SID_LEN: begin
          if (b > SID_MAX) begin
            bad = 1'b1;
          end else begin
            e_v = 1'b1;
            e_r = mk_rec(KIND_SID_LEN, {8'd0, b}, '0, '0, STATUS_OK, '0);
            if (b == 8'd0) begin
              phase_d = PH_CS_HI;
            end else begin
              field_count_d = {8'd0, b};
              phase_d       = PH_SID;
            end
          end
        end
        PH_SID: begin
          field_count_d = fc_dec;
          if (fc_dec == '0) phase_d = PH_CS_HI;
        end
        PH_CS_HI: begin
          high_byte_d = b;
          phase_d     = PH_CS_LO;
        end
        PH_CS_LO: begin
          if (word[0]) begin
            bad = 1'b1;
          end else if (word == '0) begin
            phase_d = PH_COMP_LEN;
          end else begin
            field_count_d = word;
            phase_d       = PH_SUITES;
          end
        end
        PH_SUITES: begin
          if (!field_count_q[0]) begin
            high_byte_d = b;
          end else begin
            e_v = 1'b1;
            e_r = mk_rec(KIND_SUITE, word, '0, '0, STATUS_OK, '0);
          end
          field_count_d = fc_dec;
          if (fc_dec == '0) phase_d = PH_COMP_LEN;
        end
        PH_COMP_LEN: begin
          if (b == 8'd0) begin
            phase_d = PH_EXTS_HI;
          end else begin
            field_count_d = {8'd0, b};
            phase_d       = PH_COMP;
          end
        end
        PH_COMP: begin
          e_v = 1'b1;
          e_r = mk_rec(KIND_COMP, {8'd0, b}, '0, '0, STATUS_OK, '0);
          field_count_d = fc_dec;
          if (fc_dec == '0) phase_d = PH_EXTS_HI;
        end
        PH_EXTS_HI: begin
          high_byte_d = b;
          phase_d     = PH_EXTS_LO;
        end
        PH_EXTS_LO: begin
          ext_region_end_d = sat_add(pos, {1'b0, word});
          if (word == '0) begin
            phase_d = PH_DONE;
          end else begin
            field_count_d = word;
            hdr_index_d   = 2'd0;
            phase_d       = PH_EXT_HDR;
          end
        end
        PH_EXT_HDR: begin
          field_count_d = fc_dec;
          case (hdr_index_q)
            2'd0:    high_byte_d    = b;
            2'd1:    ext_type_d     = word;
            2'd2:    high_byte_d    = b;
            default: field_length_d = word;
          endcase
          if (hdr_index_q == 2'd3) begin
            // header complete: type and length known
            hdr_index_d       = 2'd0;
            ext_data_offset_d = pos;
            if (word > fc_dec) begin
              phase_d = PH_DOOMED;
            end else if (word == '0) begin
              e_v = 1'b1;
              e_r = mk_rec(KIND_EXT, ext_type_q, '0, pos, STATUS_OK, '0);
              phase_d = (fc_dec == '0) ? PH_DONE : PH_EXT_HDR;
            end else begin
              data_left_d = word;
              phase_d     = PH_EXT_DATA;
            end
          end else begin
            hdr_index_d = hdr_index_q + 2'd1;
            if (fc_dec == '0) phase_d = PH_DOOMED;
          end
        end
        PH_EXT_DATA: begin
          if (field_count_q != '0) field_count_d = fc_dec;
          if (data_left_q != '0) data_left_d = dl_dec;
          if (data_left_q == '0 || dl_dec == '0) begin
            e_v = 1'b1;
            e_r = mk_rec(KIND_EXT, ext_type_q, field_length_q, ext_data_offset_q,
                         STATUS_OK, '0);
            hdr_index_d = 2'd0;
            phase_d = (field_count_d == '0) ? PH_DONE : PH_EXT_HDR;
          end
        end
        default: ;
      endcase

      // final status on the last byte of the buffer
      if (!bad && last) begin
        s_v = 1'b1;
        if (phase_d == PH_EXTS_HI) begin
          s_r = mk_rec(KIND_STATUS, '0, '0, '0, STATUS_OK, byte_offset_d);
        end else if (phase_d == PH_DONE) begin
          s_r = mk_rec(KIND_STATUS, '0, '0, '0, STATUS_OK, ext_region_end_d);
        end else begin
          s_r = mk_rec(KIND_STATUS, '0, '0, '0, STATUS_INCOMPLETE, '0);
        end
      end
      clear_st = bad || last;
    end

    if (clear_st) begin
      phase_d           = PH_VER_HI;
      field_count_d     = '0;
      field_length_d    = '0;
      byte_offset_d     = '0;
      ext_region_end_d  = '0;
      ext_type_d        = '0;
      ext_data_offset_d = '0;
      high_byte_d       = '0;
      discarding_d      = 1'b0;
      hdr_index_d       = '0;
      data_left_d       = '0;
    end
    // malformed: drop bytes through the next final byte
    if (bad && !last) discarding_d = 1'b1;
  end

  // Pack records for the queue; last_of_run marks the final one
  always_comb begin
    pair = '0;
    if (bad) begin
      pair.rec0 = mk_rec(KIND_STATUS, '0, '0, '0, STATUS_MALFORMED, '0);
      pair.rec0.last_of_run = 1'b1;
    end else if (e_v && s_v) begin
      pair.rec0 = e_r;
      pair.rec1 = s_r;
      pair.rec1.last_of_run = 1'b1;
      pair.two  = 1'b1;
    end else if (e_v) begin
      pair.rec0 = e_r;
      pair.rec0.last_of_run = 1'b1;
    end else begin
      pair.rec0 = s_r;
      pair.rec0.last_of_run = 1'b1;
    end
  end

  assign push_o      = bad || e_v || s_v;
  assign push_data_o = pair;

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q           <= PH_VER_HI;
      field_count_q     <= '0;
      field_length_q    <= '0;
      byte_offset_q     <= '0;
      ext_region_end_q  <= '0;
      ext_type_q        <= '0;
      ext_data_offset_q <= '0;
      high_byte_q       <= '0;
      discarding_q      <= 1'b0;
      hdr_index_q       <= '0;
      data_left_q       <= '0;
    end else begin
      phase_q           <= phase_d;
      field_count_q     <= field_count_d;
      field_length_q    <= field_length_d;
      byte_offset_q     <= byte_offset_d;
      ext_region_end_q  <= ext_region_end_d;
      ext_type_q        <= ext_type_d;
      ext_data_offset_q <= ext_data_offset_d;
      high_byte_q       <= high_byte_d;
      discarding_q      <= discarding_d;
      hdr_index_q       <= hdr_index_d;
      data_left_q       <= data_left_d;
    end
  end

endmodule

>>> rtl/chp_queue.sv
// Short queue of record pairs between the parser front and the output back.
module chp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  chp_pkg::pair_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output chp_pkg::pair_t data_o
);
  import chp_pkg::*;

  pair_t               slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= push_data_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/chp_back.sv
// Output back: splits queued pairs into single records on a registered stream.
module chp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  chp_pkg::pair_t q_data_i,
  output logic           pop_o,
  chp_rec_if.source      rec_o
);
  import chp_pkg::*;

  logic out_valid_q;
  rec_t out_rec_q;
  logic pend_q;
  rec_t pend_rec_q;
  logic advance;

  assign advance = !out_valid_q || rec_o.ready;
  assign pop_o   = advance && !pend_q && q_valid_i;

  // Output register and held second record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_rec_q   <= '0;
      pend_q      <= 1'b0;
      pend_rec_q  <= '0;
    end else if (advance) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        out_rec_q   <= pend_rec_q;
        pend_q      <= 1'b0;
      end else if (q_valid_i) begin
        out_valid_q <= 1'b1;
        out_rec_q   <= q_data_i.rec0;
        pend_q      <= q_data_i.two;
        pend_rec_q  <= q_data_i.rec1;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rec_o.valid       = out_valid_q;
  assign rec_o.record_kind = out_rec_q.record_kind;
  assign rec_o.value       = out_rec_q.value;
  assign rec_o.ext_length  = out_rec_q.ext_length;
  assign rec_o.ext_offset  = out_rec_q.ext_offset;
  assign rec_o.status      = out_rec_q.status;
  assign rec_o.consumed    = out_rec_q.consumed;
  assign rec_o.last_of_run = out_rec_q.last_of_run;

endmodule
